// ===== src/assert_macros.svh =====
// Assertion macros used by the interpolator core.
// Each macro expects a clock named clk and an active-high reset named rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/wli_pkg.sv =====
// Shared constants and types of the windowed Lagrange interpolator.
// No dependencies.
package wli_pkg;

  localparam int MAX_NODES  = 16;
  localparam int IDX_W      = 4;
  localparam int CNT_W      = 5;
  localparam int DATA_W     = 32;
  localparam int FRAC_BITS  = 16;
  localparam int WIN_BEFORE = 4;
  localparam int WIN_AFTER  = 3;

  // t - x and x_i - x_j need one bit more than the operands
  localparam int DIFF_W = DATA_W + 1;
  // (|num| << FRAC_BITS) and the ratio that comes out of it
  localparam int QUO_W  = DIFF_W + FRAC_BITS;
  // basis and term magnitudes cap at 2^58
  localparam int MAG_W  = 59;
  localparam int PROD_W = MAG_W + QUO_W;
  localparam int STEP_W = $clog2(QUO_W + 1);
  localparam int SUM_W  = 64;

  localparam logic [MAG_W-1:0] MAG_CAP = MAG_W'(1) << (MAG_W - 1);
  localparam logic [MAG_W-1:0] ONE_FX  = MAG_W'(1) << FRAC_BITS;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_SAT = 2'd1;
  localparam logic [1:0] ST_DUP = 2'd2;

  localparam logic [2:0] ADDR_NODE_COUNT = 3'd0;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

// ===== src/wli_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on wli_pkg.
module wli_div import wli_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [QUO_W-1:0]   dividend,
  input  logic [DIFF_W-1:0]  divisor,
  output logic [QUO_W-1:0]   quotient,
  output unit_stat_t         stat
);

  logic [QUO_W-1:0]  dvd;
  logic [DIFF_W-1:0] dsr;
  logic [DIFF_W-1:0] rem;
  logic [STEP_W-1:0] cnt;
  logic [DIFF_W:0]   trial;
  logic [DIFF_W:0]   diff;
  logic              fits;

  assign trial = {rem, dvd[QUO_W-1]};
  assign fits  = trial >= {1'b0, dsr};
  assign diff  = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        stat.busy <= 1'b1;
        cnt       <= STEP_W'(QUO_W);
      end else if (stat.busy) begin
        cnt <= cnt - STEP_W'(1);
        if (cnt == STEP_W'(1)) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd      <= dividend;
      dsr      <= divisor;
      rem      <= '0;
      quotient <= '0;
    end else if (stat.busy) begin
      rem      <= fits ? diff[DIFF_W-1:0] : trial[DIFF_W-1:0];
      dvd      <= {dvd[QUO_W-2:0], 1'b0};
      quotient <= {quotient[QUO_W-2:0], fits};
    end
  end

endmodule

// ===== src/wli_mul.sv =====
// Shift-add multiplier, one multiplier bit per cycle, with the fixed-point
// shift and magnitude cap applied to the product. Depends on wli_pkg.
module wli_mul import wli_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [MAG_W-1:0]  op_a,
  input  logic [QUO_W-1:0]  op_b,
  output logic [MAG_W-1:0]  product,
  output logic              sat,
  output unit_stat_t        stat
);

  localparam int HI_W = PROD_W - FRAC_BITS;

  logic [MAG_W-1:0]  a_reg;
  logic [QUO_W-1:0]  b_reg;
  logic [PROD_W-1:0] acc;
  logic [STEP_W-1:0] cnt;
  logic [HI_W-1:0]   hi;

  assign hi      = acc[PROD_W-1:FRAC_BITS];
  assign sat     = hi > HI_W'(MAG_CAP);
  assign product = sat ? MAG_CAP : hi[MAG_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        stat.busy <= 1'b1;
        cnt       <= STEP_W'(QUO_W);
      end else if (stat.busy) begin
        cnt <= cnt - STEP_W'(1);
        if (cnt == STEP_W'(1)) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

  // MSB first: acc = 2*acc + bit*a
  always_ff @(posedge clk) begin
    if (start) begin
      a_reg <= op_a;
      b_reg <= op_b;
      acc   <= '0;
    end else if (stat.busy) begin
      acc   <= {acc[PROD_W-2:0], 1'b0} + (b_reg[QUO_W-1] ? PROD_W'(a_reg) : '0);
      b_reg <= {b_reg[QUO_W-2:0], 1'b0};
    end
  end

endmodule

// ===== src/windowed_lagrange_interpolator_core.sv =====
// Top level of the windowed Lagrange interpolator: node tables, sequencer,
// config register and stream ports. Depends on wli_pkg, wli_div, wli_mul.
//
//   channel   dir  handshake                payload
//   s_*       in   s_tvalid / s_tready      tuser=mode, tdata=index,x,y,query
//   m_*       out  m_tvalid / m_tready      tdata=value,status
//   apb       in   psel/penable/pready      node_count at address 0
//
// A load transaction writes its node into the tables as it is accepted. An
// evaluate transaction reads and compares each node examined in the search,
// sets up the window, then for each window node reads x_i and y_i, passes over
// the pair of the node with itself, divides and multiplies for each other node
// and scales by y; saturation and output follow. One divider and one multiplier
// are shared by all these steps. s_tready is low while an evaluation runs;
// one finished result may wait in the output register.
// Reset is synchronous, active high; the node tables are not cleared.
module windowed_lagrange_interpolator_core import wli_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [103:0] s_tdata,  // node_index[3:0], node_x, node_y, query_point, pad
  input  logic         s_tuser,  // mode
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [39:0]  m_tdata,  // value[31:0], status[33:32], pad
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  `include "assert_macros.svh"

  typedef enum logic [13:0] {
    S_IDLE     = 14'b00000000000001,
    S_SRCH_RD  = 14'b00000000000010,
    S_SRCH_CMP = 14'b00000000000100,
    S_WIN      = 14'b00000000001000,
    S_XI_RD    = 14'b00000000010000,
    S_XI_LD    = 14'b00000000100000,
    S_XJ_RD    = 14'b00000001000000,
    S_XJ       = 14'b00000010000000,
    S_DIV      = 14'b00000100000000,
    S_MUL_R    = 14'b00001000000000,
    S_YGO      = 14'b00010000000000,
    S_MUL_Y    = 14'b00100000000000,
    S_FIN      = 14'b01000000000000,
    S_OUT      = 14'b10000000000000
  } state_t;

  state_t state;

  logic [DATA_W-1:0] table_x [MAX_NODES];
  logic [DATA_W-1:0] table_y [MAX_NODES];
  logic [IDX_W-1:0]  ra;
  logic signed [DATA_W-1:0] rdx, rdy;

  logic [CNT_W-1:0] node_count, n_eff, n, pos, lo, hi, i, j;
  logic signed [DATA_W-1:0] t, xi, yi;
  logic [MAG_W-1:0] s;
  logic             neg, sat;
  logic signed [SUM_W-1:0] sum;
  logic [DATA_W-1:0] res_value;
  logic [1:0]        res_status;

  logic signed [DIFF_W-1:0] num, den;
  logic [DIFF_W-1:0] num_mag, den_mag;
  logic [CNT_W:0]    hi_raw;
  logic              j_skip;

  logic              div_start, mul_start;
  logic [QUO_W-1:0]  quo, mul_b;
  logic [MAG_W-1:0]  mul_p;
  logic              mul_sat;
  unit_stat_t        div_stat, mul_stat;

  logic cfg_wr;
  logic s_acc;

  assign pready   = 1'b1;
  assign prdata   = {{(32-CNT_W){1'b0}}, node_count};
  assign cfg_wr   = psel && penable && pwrite && (paddr[2] == ADDR_NODE_COUNT[2]);
  assign s_tready = (state == S_IDLE);
  assign s_acc    = s_tvalid && s_tready;
  assign n_eff    = (node_count > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : node_count;

  assign num     = DIFF_W'(t) - DIFF_W'(rdx);
  assign den     = DIFF_W'(xi) - DIFF_W'(rdx);
  assign num_mag = num[DIFF_W-1] ? -num : num;
  assign den_mag = den[DIFF_W-1] ? -den : den;
  assign hi_raw  = {1'b0, pos} + (CNT_W+1)'(WIN_AFTER);
  assign j_skip  = (j == i);

  assign div_start = (state == S_XJ) && !j_skip && (den != '0);
  assign mul_start = ((state == S_DIV) && div_stat.done) || (state == S_YGO);
  // widen before negating so that the most negative y gives 2^31
  assign mul_b     = (state == S_YGO) ?
                     QUO_W'(yi[DATA_W-1] ? -DIFF_W'(yi) : DIFF_W'(yi)) : quo;

  always_comb begin
    unique case (state)
      S_SRCH_RD: ra = pos[IDX_W-1:0];
      S_XI_RD:   ra = i[IDX_W-1:0];
      default:   ra = j[IDX_W-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    rdx <= table_x[ra];
    rdy <= table_y[ra];
    if (s_acc && !s_tuser && ({1'b0, s_tdata[3:0]} < CNT_W'(MAX_NODES))) begin
      table_x[s_tdata[3:0]] <= s_tdata[35:4];
      table_y[s_tdata[3:0]] <= s_tdata[67:36];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= '0;
    end else if (cfg_wr) begin
      node_count <= pwdata[CNT_W-1:0];
    end
  end

  wli_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({num_mag, {FRAC_BITS{1'b0}}}),
    .divisor  (den_mag),
    .quotient (quo),
    .stat     (div_stat)
  );

  wli_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .op_a    (s),
    .op_b    (mul_b),
    .product (mul_p),
    .sat     (mul_sat),
    .stat    (mul_stat)
  );

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_OUT) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (s_acc && s_tuser) state <= (n_eff == '0) ? S_FIN : S_SRCH_RD;
        end
        S_SRCH_RD: state <= S_SRCH_CMP;
        S_SRCH_CMP: begin
          if (rdx < t && pos + CNT_W'(1) != n) state <= S_SRCH_RD;
          else state <= S_WIN;
        end
        S_WIN:   state <= S_XI_RD;
        S_XI_RD: state <= S_XI_LD;
        S_XI_LD: state <= S_XJ_RD;
        S_XJ_RD: state <= S_XJ;
        S_XJ: begin
          if (j_skip) state <= (j == hi) ? S_YGO : S_XJ_RD;
          else if (den == '0) state <= S_OUT;
          else state <= S_DIV;
        end
        S_DIV: begin
          if (div_stat.done) state <= S_MUL_R;
        end
        S_MUL_R: begin
          if (mul_stat.done) state <= (j == hi) ? S_YGO : S_XJ_RD;
        end
        S_YGO: state <= S_MUL_Y;
        S_MUL_Y: begin
          if (mul_stat.done) state <= (i == hi) ? S_FIN : S_XI_RD;
        end
        S_FIN: state <= S_OUT;
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        t   <= s_tdata[99:68];
        n   <= n_eff;
        pos <= '0;
        sum <= '0;
        sat <= 1'b0;
      end
      S_SRCH_CMP: begin
        if (rdx < t) pos <= pos + CNT_W'(1);
      end
      S_WIN: begin
        lo <= (pos >= CNT_W'(WIN_BEFORE)) ? pos - CNT_W'(WIN_BEFORE) : '0;
        hi <= (hi_raw > {1'b0, n - CNT_W'(1)}) ? n - CNT_W'(1) : hi_raw[CNT_W-1:0];
        i  <= (pos >= CNT_W'(WIN_BEFORE)) ? pos - CNT_W'(WIN_BEFORE) : '0;
      end
      S_XI_LD: begin
        xi  <= rdx;
        yi  <= rdy;
        j   <= lo;
        s   <= ONE_FX;
        neg <= 1'b0;
      end
      S_XJ: begin
        if (j_skip) begin
          j <= j + CNT_W'(1);
        end else if (den == '0) begin
          res_value  <= '0;
          res_status <= ST_DUP;
        end else if (num[DIFF_W-1] != den[DIFF_W-1]) begin
          neg <= !neg;
        end
      end
      S_MUL_R: begin
        if (mul_stat.done) begin
          s   <= mul_p;
          sat <= sat | mul_sat;
          j   <= j + CNT_W'(1);
        end
      end
      S_YGO: begin
        if (yi[DATA_W-1]) neg <= !neg;
      end
      S_MUL_Y: begin
        if (mul_stat.done) begin
          sat <= sat | mul_sat;
          sum <= neg ? sum - SUM_W'(mul_p) : sum + SUM_W'(mul_p);
          i   <= i + CNT_W'(1);
        end
      end
      S_FIN: begin
        if (sum > SUM_W'(32'sh7FFFFFFF)) begin
          res_value  <= 32'h7FFFFFFF;
          res_status <= ST_SAT;
        end else if (sum < -SUM_W'(64'sh80000000)) begin
          res_value  <= 32'h80000000;
          res_status <= ST_SAT;
        end else begin
          res_value  <= sum[DATA_W-1:0];
          res_status <= sat ? ST_SAT : ST_OK;
        end
      end
      S_OUT: begin
        if (!m_tvalid || m_tready) m_tdata <= {6'b0, res_status, res_value};
      end
      default: ;
    endcase
  end

  `ASSERT_IMPL(a_div_free, div_start, !div_stat.busy, "divider started while busy")
  `ASSERT_NEXT(a_mul_run, mul_start, mul_stat.busy, "multiplier did not start")
  `ASSERT_IMPL(a_win_range, state == S_XJ, (lo <= j) && (j <= hi) && (i <= hi),
               "window index out of range")
  `ASSERT_IMPL(a_dup_zero, m_tvalid && (m_tdata[33:32] == ST_DUP), m_tdata[31:0] == '0,
               "duplicate-x result not zero")

endmodule
